// File: hw/rtl/tfit_pkg.sv
// Shared types and constants for the tolerant float index table.
// No dependencies.
package tfit_pkg;

  localparam int DEF_CAPACITY   = 1024;
  localparam int DEF_INDEX_BITS = 10;
  localparam int DBL_W = 64;
  localparam int IDX_W = 20;
  localparam int CNT_W = 10;

  localparam logic [1:0] OP_PUT_ONE  = 2'd0;
  localparam logic [1:0] OP_PUT_PAIR = 2'd1;
  localparam logic [1:0] OP_GET_ONE  = 2'd2;
  localparam logic [1:0] OP_GET_PAIR = 2'd3;

  localparam logic [1:0] ST_NEW   = 2'd0;
  localparam logic [1:0] ST_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE,
    S_GET_A,
    S_GET_B,
    S_GET_C
  } state_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [DBL_W-1:0] value_re;
    logic [DBL_W-1:0] value_im;
    logic [IDX_W-1:0] index_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] result_index;
    logic [DBL_W-1:0] out_re;
    logic [DBL_W-1:0] out_im;
    logic [CNT_W-1:0] count_now;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic match;
  } close_res_t;

endpackage

// File: hw/rtl/tfit_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tfit_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/tfit_close.sv
// Four-stage pipelined |a - b| < tolerance test on IEEE doubles (exact when tol is zero).
// Depends on tfit_pkg.
module tfit_close #(
  parameter int TAG_W = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [tfit_pkg::DBL_W-1:0] a,
  input  logic [tfit_pkg::DBL_W-1:0] b,
  input  logic [TAG_W-1:0]          in_tag,
  input  logic [tfit_pkg::DBL_W-1:0] tol,
  output tfit_pkg::close_res_t      res,
  output logic [TAG_W-1:0]          res_tag,
  output logic [tfit_pkg::DBL_W-1:0] res_val,
  output logic                      busy
);

  // stage 1: classify, order, align
  logic [62:0] a_mag, b_mag, big, sml;
  logic [10:0] e_b, e_s, ee_b, ee_s, dexp;
  logic [52:0] m_b, m_s;
  logic [5:0]  dsh;
  logic [55:0] ext, shr, aligned;
  logic        stk, nan_a, nan_b, inf_a, inf_b, eff_sub, eq, nan_c, inf_c;

  always_comb begin
    a_mag   = a[62:0];
    b_mag   = b[62:0];
    eff_sub = (a[63] == b[63]);
    nan_a   = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    nan_b   = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    inf_a   = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
    inf_b   = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
    eq      = !nan_a && !nan_b && ((a == b) || (a_mag == 63'd0 && b_mag == 63'd0));
    nan_c   = nan_a || nan_b || (inf_a && inf_b && eff_sub);
    inf_c   = !nan_c && (inf_a || inf_b);
    if (a_mag >= b_mag) begin
      big = a_mag;
      sml = b_mag;
    end else begin
      big = b_mag;
      sml = a_mag;
    end
    e_b  = big[62:52];
    e_s  = sml[62:52];
    m_b  = {(e_b != 11'd0), big[51:0]};
    m_s  = {(e_s != 11'd0), sml[51:0]};
    ee_b = (e_b == 11'd0) ? 11'd1 : e_b;
    ee_s = (e_s == 11'd0) ? 11'd1 : e_s;
    dexp = ee_b - ee_s;
    dsh  = (dexp > 11'd56) ? 6'd56 : dexp[5:0];
    ext  = {m_s, 3'b000};
    shr  = ext >> dsh;
    stk  = ((shr << dsh) != ext);
    aligned = {shr[55:1], shr[0] | stk};
  end

  logic                       v1_r, v2_r, v3_r, v4_r;
  logic [TAG_W-1:0]           t1_r, t2_r, t3_r, t4_r;
  logic [tfit_pkg::DBL_W-1:0] b1_r, b2_r, b3_r, b4_r;
  logic                       eq1_r, eq2_r, eq3_r;
  logic                       nan1_r, nan2_r, nan3_r;
  logic                       inf1_r, inf2_r, inf3_r;
  logic                       sub1_r, match4_r;
  logic [55:0]                mb1_r, al1_r, r2_r, r3_r;
  logic [11:0]                e1_r, e2_r, e3_r;

  // stage 2: add or subtract magnitudes
  logic [56:0] sum57;
  logic [55:0] r2_nxt;
  logic [11:0] e2_nxt;

  always_comb begin
    sum57 = sub1_r ? ({1'b0, mb1_r} - {1'b0, al1_r}) : ({1'b0, mb1_r} + {1'b0, al1_r});
    if (sum57[56]) begin
      r2_nxt = {sum57[56:2], sum57[1] | sum57[0]};
      e2_nxt = e1_r + 12'd1;
    end else begin
      r2_nxt = sum57[55:0];
      e2_nxt = e1_r;
    end
  end

  // stage 3: normalize, floored at the subnormal exponent
  logic [5:0]  lz, shamt;
  logic [11:0] lim;
  logic [55:0] r3_nxt;
  logic [11:0] e3_nxt;

  always_comb begin
    lz = 6'd56;
    for (int i = 0; i < 56; i++) begin
      if (r2_r[i]) lz = 6'(55 - i);
    end
    lim    = e2_r - 12'd1;
    shamt  = ({6'd0, lz} > lim) ? lim[5:0] : lz;
    r3_nxt = r2_r << shamt;
    e3_nxt = e2_r - {6'd0, shamt};
  end

  // stage 4: round to nearest even, pack, compare
  logic        over, up, tol_zero, tol_pos, match4_nxt;
  logic [10:0] ef;
  logic [62:0] packed_mag, mag;

  always_comb begin
    over       = (e3_r >= 12'd2047);
    ef         = r3_r[55] ? e3_r[10:0] : 11'd0;
    up         = r3_r[2] & (r3_r[1] | r3_r[0] | r3_r[3]);
    packed_mag = {ef, r3_r[54:3]} + {62'd0, up};
    mag        = (over || inf3_r) ? {11'h7FF, 52'd0} : packed_mag;
    tol_zero   = (tol[62:0] == 63'd0);
    tol_pos    = !tol[63] && !((tol[62:52] == 11'h7FF) && (tol[51:0] != 52'd0));
    match4_nxt = tol_zero ? eq3_r : (tol_pos && !nan3_r && (mag < tol[62:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_r     <= in_tag;
    b1_r     <= b;
    eq1_r    <= eq;
    nan1_r   <= nan_c;
    inf1_r   <= inf_c;
    sub1_r   <= eff_sub;
    mb1_r    <= {m_b, 3'b000};
    al1_r    <= aligned;
    e1_r     <= {1'b0, ee_b};
    t2_r     <= t1_r;
    b2_r     <= b1_r;
    eq2_r    <= eq1_r;
    nan2_r   <= nan1_r;
    inf2_r   <= inf1_r;
    r2_r     <= r2_nxt;
    e2_r     <= e2_nxt;
    t3_r     <= t2_r;
    b3_r     <= b2_r;
    eq3_r    <= eq2_r;
    nan3_r   <= nan2_r;
    inf3_r   <= inf2_r;
    r3_r     <= r3_nxt;
    e3_r     <= e3_nxt;
    t4_r     <= t3_r;
    b4_r     <= b3_r;
    match4_r <= match4_nxt;
  end

  assign res.valid = v4_r;
  assign res.match = match4_r;
  assign res_tag   = t4_r;
  assign res_val   = b4_r;
  assign busy      = v1_r | v2_r | v3_r | v4_r;

endmodule

// File: hw/rtl/tolerant_float_index_table_top.sv
// Tolerant float index table: interns doubles into a RAM, find-or-put and get.
// Find-or-put reads each stored entry from RAM in turn, stopping issue at a match, then
// drains the compare pipeline; pairs run two parts. Get reads one entry (one) or two (pair).
// Result is registered and shows in the cycle after the last step; next item may start then.
// Synchronous active-low reset empties the table and clears tolerance; no clearing pass.
// Depends on tfit_pkg, tfit_ram, tfit_close.
module tolerant_float_index_table_top #(
  parameter int CAPACITY   = tfit_pkg::DEF_CAPACITY,
  parameter int INDEX_BITS = tfit_pkg::DEF_INDEX_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  tfit_pkg::in_item_t         in_item,
  output logic                       out_valid,
  output tfit_pkg::out_item_t        out_item,
  input  logic                       cfg_we,
  input  logic [tfit_pkg::DBL_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int IW = tfit_pkg::IDX_W;
  localparam int CW = tfit_pkg::CNT_W;
  localparam int DW = tfit_pkg::DBL_W;
  localparam logic [IW-1:0] IMASK = IW'((1 << INDEX_BITS) - 1);
  localparam logic [AW:0]   FULL_AT = (AW+1)'(CAPACITY - 1);

  tfit_pkg::state_t state_r, state_nxt;

  logic [1:0]    op_r, op_nxt;
  logic [DW-1:0] val_r, val_nxt, vim_r, vim_nxt, tol_r;
  logic [IW-1:0] iin_r, iin_nxt;
  logic          part_r, part_nxt, hit_r, hit_nxt, rd_pend_r, rd_pend_nxt;
  logic [AW-1:0] issue_k_r, issue_k_nxt, rd_idx_r, rd_idx_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt, count_r, count_nxt, k0_r, k0_nxt;
  logic [DW-1:0] hit_val_r, hit_val_nxt, v0_r, v0_nxt;
  logic [1:0]    s0_r, s0_nxt;
  logic          out_valid_nxt;
  tfit_pkg::out_item_t out_item_r, out_item_nxt;

  logic          we, issue, acc, is_get, get_ok, full, scan_done, pair_more;
  logic [AW-1:0] raddr;
  logic [DW-1:0] rdata, pipe_val;
  logic [AW-1:0] pipe_tag;
  logic          pipe_busy;
  tfit_pkg::close_res_t pipe_res;
  logic [IW-1:0] cnt20, ri_in, ii_in, ri_r, ii_r;
  logic [1:0]    p_st;
  logic [AW-1:0] p_k;
  logic [DW-1:0] p_v;

  tfit_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (count_r),
    .wdata (val_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  tfit_close #(.TAG_W(AW)) u_close (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rd_pend_r),
    .a        (val_r),
    .b        (rdata),
    .in_tag   (rd_idx_r),
    .tol      (tol_r),
    .res      (pipe_res),
    .res_tag  (pipe_tag),
    .res_val  (pipe_val),
    .busy     (pipe_busy)
  );

  always_comb begin
    acc       = start && !busy;
    cnt20     = IW'(count_r);
    ri_in     = in_item.index_in >> INDEX_BITS;
    ii_in     = in_item.index_in & IMASK;
    ri_r      = iin_r >> INDEX_BITS;
    ii_r      = iin_r & IMASK;
    is_get    = (in_item.operation == tfit_pkg::OP_GET_ONE) ||
                (in_item.operation == tfit_pkg::OP_GET_PAIR);
    get_ok    = (in_item.operation == tfit_pkg::OP_GET_ONE) ? (in_item.index_in < cnt20)
                : ((ri_in < cnt20) && (ii_in < cnt20));
    full      = ({1'b0, count_r} >= FULL_AT);
    issue     = (state_r == tfit_pkg::S_SCAN) && !hit_r && (issue_k_r < count_r);
    scan_done = (hit_r || (issue_k_r >= count_r)) && !rd_pend_r && !pipe_busy;
    if (hit_r) begin
      p_st = tfit_pkg::ST_FOUND;
      p_k  = hit_idx_r;
      p_v  = hit_val_r;
    end else if (full) begin
      p_st = tfit_pkg::ST_FULL;
      p_k  = count_r;
      p_v  = val_r;
    end else begin
      p_st = tfit_pkg::ST_NEW;
      p_k  = count_r;
      p_v  = val_r;
    end
    pair_more = (op_r == tfit_pkg::OP_PUT_PAIR) && !part_r && (p_st != tfit_pkg::ST_FULL);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tfit_pkg::S_IDLE: begin
        if (acc) begin
          if (!is_get) state_nxt = tfit_pkg::S_SCAN;
          else if (get_ok) state_nxt = tfit_pkg::S_GET_A;
        end
      end
      tfit_pkg::S_SCAN:    if (scan_done) state_nxt = tfit_pkg::S_RESOLVE;
      tfit_pkg::S_RESOLVE: state_nxt = pair_more ? tfit_pkg::S_SCAN : tfit_pkg::S_IDLE;
      tfit_pkg::S_GET_A:   state_nxt = tfit_pkg::S_GET_B;
      tfit_pkg::S_GET_B: begin
        state_nxt = (op_r == tfit_pkg::OP_GET_PAIR) ? tfit_pkg::S_GET_C : tfit_pkg::S_IDLE;
      end
      tfit_pkg::S_GET_C:   state_nxt = tfit_pkg::S_IDLE;
      default:             state_nxt = tfit_pkg::S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    op_nxt        = op_r;
    val_nxt       = val_r;
    vim_nxt       = vim_r;
    iin_nxt       = iin_r;
    part_nxt      = part_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_val_nxt   = hit_val_r;
    issue_k_nxt   = issue_k_r;
    rd_pend_nxt   = issue;
    rd_idx_nxt    = issue_k_r;
    count_nxt     = count_r;
    k0_nxt        = k0_r;
    v0_nxt        = v0_r;
    s0_nxt        = s0_r;
    we            = 1'b0;
    raddr         = issue_k_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    case (state_r)
      tfit_pkg::S_IDLE: begin
        if (acc) begin
          op_nxt      = in_item.operation;
          val_nxt     = in_item.value_re;
          vim_nxt     = in_item.value_im;
          iin_nxt     = in_item.index_in;
          part_nxt    = 1'b0;
          hit_nxt     = 1'b0;
          issue_k_nxt = '0;
          if (is_get && !get_ok) begin
            out_valid_nxt             = 1'b1;
            out_item_nxt.status       = tfit_pkg::ST_BAD;
            out_item_nxt.result_index = in_item.index_in;
            out_item_nxt.out_re       = '0;
            out_item_nxt.out_im       = '0;
            out_item_nxt.count_now    = CW'(count_r);
          end
        end
      end
      tfit_pkg::S_SCAN: begin
        if (issue) issue_k_nxt = issue_k_r + 1'b1;
        if (pipe_res.valid && pipe_res.match && !hit_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = pipe_tag;
          hit_val_nxt = pipe_val;
        end
      end
      tfit_pkg::S_RESOLVE: begin
        if (p_st == tfit_pkg::ST_NEW) begin
          we        = 1'b1;
          count_nxt = count_r + 1'b1;
        end
        if (pair_more) begin
          part_nxt    = 1'b1;
          s0_nxt      = p_st;
          k0_nxt      = p_k;
          v0_nxt      = p_v;
          val_nxt     = vim_r;
          hit_nxt     = 1'b0;
          issue_k_nxt = '0;
        end else begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.count_now = CW'(count_nxt);
          out_item_nxt.out_im    = '0;
          if (p_st == tfit_pkg::ST_FULL) begin
            out_item_nxt.status       = tfit_pkg::ST_FULL;
            out_item_nxt.result_index = '0;
            out_item_nxt.out_re       = '0;
          end else if (op_r == tfit_pkg::OP_PUT_ONE) begin
            out_item_nxt.status       = p_st;
            out_item_nxt.result_index = IW'(p_k);
            out_item_nxt.out_re       = p_v;
          end else begin
            out_item_nxt.status = ((s0_r == tfit_pkg::ST_FOUND) &&
                                   (p_st == tfit_pkg::ST_FOUND)) ?
                                  tfit_pkg::ST_FOUND : tfit_pkg::ST_NEW;
            out_item_nxt.result_index = IW'((32'(k0_r) << INDEX_BITS) | 32'(p_k));
            out_item_nxt.out_re       = v0_r;
            out_item_nxt.out_im       = p_v;
          end
        end
      end
      tfit_pkg::S_GET_A: begin
        raddr = (op_r == tfit_pkg::OP_GET_PAIR) ? AW'(ri_r) : AW'(iin_r);
      end
      tfit_pkg::S_GET_B: begin
        v0_nxt = rdata;
        raddr  = AW'(ii_r);
        if (op_r != tfit_pkg::OP_GET_PAIR) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.status       = tfit_pkg::ST_FOUND;
          out_item_nxt.result_index = iin_r;
          out_item_nxt.out_re       = rdata;
          out_item_nxt.out_im       = '0;
          out_item_nxt.count_now    = CW'(count_r);
        end
      end
      tfit_pkg::S_GET_C: begin
        out_valid_nxt             = 1'b1;
        out_item_nxt.status       = tfit_pkg::ST_FOUND;
        out_item_nxt.result_index = iin_r;
        out_item_nxt.out_re       = v0_r;
        out_item_nxt.out_im       = rdata;
        out_item_nxt.count_now    = CW'(count_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tfit_pkg::S_IDLE;
      count_r   <= '0;
      tol_r     <= '0;
      hit_r     <= 1'b0;
      rd_pend_r <= 1'b0;
      out_valid <= 1'b0;
      part_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      hit_r     <= hit_nxt;
      rd_pend_r <= rd_pend_nxt;
      out_valid <= out_valid_nxt;
      part_r    <= part_nxt;
      if (cfg_we) tol_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    vim_r      <= vim_nxt;
    iin_r      <= iin_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_val_r  <= hit_val_nxt;
    issue_k_r  <= issue_k_nxt;
    rd_idx_r   <= rd_idx_nxt;
    k0_r       <= k0_nxt;
    v0_r       <= v0_nxt;
    s0_r       <= s0_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy     = (state_r != tfit_pkg::S_IDLE);
  assign out_item = out_item_r;

endmodule

// File: hw/rtl/tfit_checker.sv
// Port-level assertions for the tolerant float index table, bound to the top level.
// Depends on tfit_pkg and tolerant_float_index_table_top.
module tfit_assertions (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input tfit_pkg::out_item_t out_item
);

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither busy nor answered");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == tfit_pkg::ST_FULL) |->
    (out_item.result_index == '0 && out_item.out_re == '0 && out_item.out_im == '0))
    else $error("full result carries data");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == tfit_pkg::ST_BAD) |->
    (out_item.out_re == '0 && out_item.out_im == '0))
    else $error("unwritten index result carries data");

  a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == tfit_pkg::ST_NEW) |-> (out_item.count_now != '0))
    else $error("insert reported with empty table");

endmodule

bind tolerant_float_index_table_top tfit_assertions u_chk (.*);
